// ----- rtl/core/framebuffer_pixel_access_assert.svh -----
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds in the same cycle as its trigger.
`define FPA_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("%m: assertion failed");

// Property holds starting in the cycle after its trigger.
`define FPA_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> prop) \
        else $error("%m: assertion failed");

`else

`define FPA_ASSERT_NOW(label, trig, prop)
`define FPA_ASSERT_NEXT(label, trig, prop)

`endif

`endif

// ----- rtl/core/fpa_pkg.sv -----
package fpa_pkg;

    typedef enum logic [1:0] {
        DEPTH_8BPP  = 2'd0,
        DEPTH_16BPP = 2'd1,
        DEPTH_24BPP = 2'd2,
        DEPTH_32BPP = 2'd3
    } depth_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LFB_ENABLED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FB_BASE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PITCH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_CODE    = 3'd5;

    typedef struct packed {
        logic               op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic        [23:0] color_in;
        logic        [31:0] raw_word;
    } fpa_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] byte_addr;
        logic [31:0] write_word;
        logic [2:0]  write_bytes;
        logic [23:0] color_out;
    } fpa_out_t;

    // Pixel data from the format unit, already zeroed on a miss.
    typedef struct packed {
        logic [31:0] write_word;
        logic [2:0]  write_bytes;
        logic [23:0] color_out;
    } fpa_fmt_t;

endpackage

// ----- rtl/core/framebuffer_pixel_access.sv -----
// Channel   Handshake              Beat
// -------   ---------------------  ---------------------------------
// command   start / busy           fpa_in_t: op, position, color, raw
// result    done strobe            fpa_out_t: hit, address, pixel data
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command is taken every cycle; busy stays low and cfg_ready stays high.
// The pipeline registers clip and pixel format, then the 15x16 row
// multiply and column scale, then the 32-bit address add into the result
// register. done pulses in the cycle the result register holds the beat.
// rst_n clears the valid bits and all configuration registers to zero.
// The receiver cannot stall, so the pipeline never holds.
module framebuffer_pixel_access (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fpa_pkg::fpa_in_t                  cmd,
    output logic                              done,
    output fpa_pkg::fpa_out_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);
    import fpa_pkg::*;

    `include "framebuffer_pixel_access_assert.svh"

    logic        lfb_enabled_reg;
    logic [31:0] fb_base_reg;
    logic [15:0] screen_width_reg;
    logic [15:0] screen_height_reg;
    logic [15:0] line_pitch_reg;
    depth_t      depth_reg;

    logic        cfg_write;
    logic        accept;
    logic        hit_next;
    fpa_fmt_t    fmt_next;

    // stage 1
    logic        s1_valid_reg;
    logic        s1_hit_reg;
    logic [14:0] s1_x_reg;
    logic [14:0] s1_y_reg;
    fpa_fmt_t    s1_fmt_reg;

    // stage 2
    logic        s2_valid_reg;
    logic        s2_hit_reg;
    logic [31:0] s2_row_reg;
    logic [16:0] s2_col_reg;
    fpa_fmt_t    s2_fmt_reg;
    logic [31:0] s2_row_next;
    logic [16:0] s2_col_next;

    // stage 3 (result)
    logic        done_reg;
    fpa_out_t    result_reg;
    logic [31:0] addr_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfb_enabled_reg   <= 1'b0;
            fb_base_reg       <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            line_pitch_reg    <= '0;
            depth_reg         <= DEPTH_8BPP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LFB_ENABLED:   lfb_enabled_reg   <= cfg_data[0];
                CFG_FB_BASE:       fb_base_reg       <= cfg_data;
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[15:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[15:0];
                CFG_LINE_PITCH:    line_pitch_reg    <= cfg_data[15:0];
                CFG_DEPTH_CODE:    depth_reg         <= depth_t'(cfg_data[1:0]);
                default:           ;
            endcase
        end
    end

    // Negative coordinates have the sign bit set and always miss.
    assign hit_next = lfb_enabled_reg && !cmd.pos_x[15] && !cmd.pos_y[15]
                   && (cmd.pos_x[15:0] < screen_width_reg)
                   && (cmd.pos_y[15:0] < screen_height_reg);

    fpa_pixel_fmt u_fmt (
        .hit      (hit_next),
        .op       (cmd.op),
        .depth    (depth_reg),
        .color_in (cmd.color_in),
        .raw_word (cmd.raw_word),
        .fmt      (fmt_next)
    );

    always_comb
    begin
        s2_row_next = 32'({17'd0, s1_y_reg} * {16'd0, line_pitch_reg});
        case (depth_reg)
            DEPTH_8BPP:  s2_col_next = {2'd0, s1_x_reg};
            DEPTH_16BPP: s2_col_next = {1'b0, s1_x_reg, 1'b0};
            DEPTH_24BPP: s2_col_next = {1'b0, s1_x_reg, 1'b0} + {2'd0, s1_x_reg};
            default:     s2_col_next = {s1_x_reg, 2'b00};
        endcase
    end

    assign addr_next = fb_base_reg + s2_row_reg + {15'd0, s2_col_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg <= hit_next;
            s1_x_reg   <= cmd.pos_x[14:0];
            s1_y_reg   <= cmd.pos_y[14:0];
            s1_fmt_reg <= fmt_next;
        end
        if (s1_valid_reg)
        begin
            s2_hit_reg <= s1_hit_reg;
            s2_row_reg <= s2_row_next;
            s2_col_reg <= s2_col_next;
            s2_fmt_reg <= s1_fmt_reg;
        end
        if (s2_valid_reg)
        begin
            result_reg.hit         <= s2_hit_reg;
            result_reg.byte_addr   <= s2_hit_reg ? addr_next : 32'd0;
            result_reg.write_word  <= s2_fmt_reg.write_word;
            result_reg.write_bytes <= s2_fmt_reg.write_bytes;
            result_reg.color_out   <= s2_fmt_reg.color_out;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `FPA_ASSERT_NEXT(a_latency, start && !busy, ##2 done)
    `FPA_ASSERT_NOW(a_miss_zero, done && !result.hit,
        result.byte_addr == 32'd0 && result.write_word == 32'd0 &&
        result.write_bytes == 3'd0 && result.color_out == 24'd0)
    `FPA_ASSERT_NOW(a_write_no_color, done && result.write_bytes != 3'd0,
        result.color_out == 24'd0 && result.hit)
    `FPA_ASSERT_NOW(a_bytes_range, done, result.write_bytes <= 3'd4)

endmodule

// ----- rtl/core/fpa_pixel_fmt.sv -----
module fpa_pixel_fmt (
    input  logic             hit,
    input  logic             op,
    input  fpa_pkg::depth_t  depth,
    input  logic [23:0]      color_in,
    input  logic [31:0]      raw_word,
    output fpa_pkg::fpa_fmt_t fmt
);
    import fpa_pkg::*;

    logic [7:0]  packed_332;
    logic [15:0] packed_565;
    logic [23:0] expand_332;
    logic [23:0] expand_565;
    logic [2:0]  bpp_bytes;

    assign packed_332 = {color_in[23:21], color_in[15:13], color_in[7:6]};
    assign packed_565 = {color_in[23:19], color_in[15:10], color_in[7:3]};

    // Replicate the top bits of each channel into its low bits.
    assign expand_332 = {raw_word[7:5], raw_word[7:5], raw_word[7:6],
                         raw_word[4:2], raw_word[4:2], raw_word[4:3],
                         raw_word[1:0], raw_word[1:0], raw_word[1:0], raw_word[1:0]};
    assign expand_565 = {raw_word[15:11], raw_word[15:13],
                         raw_word[10:5],  raw_word[10:9],
                         raw_word[4:0],   raw_word[4:2]};

    assign bpp_bytes = {1'b0, depth} + 3'd1;

    always_comb
    begin
        fmt = '0;
        if (hit)
        begin
            if (op == OP_WRITE)
            begin
                fmt.write_bytes = bpp_bytes;
                case (depth)
                    DEPTH_8BPP:  fmt.write_word = {24'd0, packed_332};
                    DEPTH_16BPP: fmt.write_word = {16'd0, packed_565};
                    default:     fmt.write_word = {8'd0, color_in};
                endcase
            end
            else
            begin
                case (depth)
                    DEPTH_8BPP:  fmt.color_out = expand_332;
                    DEPTH_16BPP: fmt.color_out = expand_565;
                    default:     fmt.color_out = raw_word[23:0];
                endcase
            end
        end
    end

endmodule
